[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while reset is low.
`define ERC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the rising clock edge that also holds through reset.
`define ERC_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/erc_pkg.sv]
package erc_pkg;

  // Longest record the converter handles; larger lengths act as this value.
  localparam int MAX_RECORD  = 63;
  // Most output beats that one input beat can cause.
  localparam int MAX_RESULTS = 64;
  // Default depth of the command queue between front and back end.
  localparam int QUEUE_DEPTH = 4;

  localparam int CNT_W = 7;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_ASPACE = 8'h20;
  localparam logic [7:0] CH_ESPACE = 8'h40;

  localparam logic ACT_FLUSH = 1'b1;

  localparam logic [1:0] CASE_UPPER = 2'd1;
  localparam logic [1:0] CASE_LOWER = 2'd2;

  typedef enum logic [1:0] {
    CFG_TRANSLATE = 2'd0,
    CFG_CASE      = 2'd1,
    CFG_SWAP      = 2'd2,
    CFG_RECLEN    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    XL_COPY      = 2'd0,
    XL_UNBLOCK   = 2'd1,
    XL_BLOCK     = 2'd2,
    XL_BLOCK_PRT = 2'd3
  } xlate_t;

  // One input beat's worth of work for the back end. The bytes it stands for are
  // rep_cnt copies of rep_byte, then mid_byte if has_mid, then a newline if
  // has_end, optionally led by the held swap byte.
  typedef struct packed {
    logic [7:0]       rep_byte;
    logic [5:0]       rep_cnt;
    logic             has_mid;
    logic [7:0]       mid_byte;
    logic             has_end;
    logic             held_in;
    logic [7:0]       held_byte;
    logic             swap;
    logic [CNT_W-1:0] slen;
    logic [CNT_W-1:0] n_out;
  } cmd_t;

  localparam logic [7:0] E2A [256] = '{
    8'h00,8'h01,8'h02,8'h03,8'h9C,8'h09,8'h86,8'h7F,8'h97,8'h8D,8'h8E,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,
    8'h10,8'h11,8'h12,8'h13,8'h9D,8'h85,8'h08,8'h87,8'h18,8'h19,8'h92,8'h8F,8'h1C,8'h1D,8'h1E,8'h1F,
    8'h80,8'h81,8'h82,8'h83,8'h84,8'h0A,8'h17,8'h1B,8'h88,8'h89,8'h8A,8'h8B,8'h8C,8'h05,8'h06,8'h07,
    8'h90,8'h91,8'h16,8'h93,8'h94,8'h95,8'h96,8'h04,8'h98,8'h99,8'h9A,8'h9B,8'h14,8'h15,8'h9E,8'h1A,
    8'h20,8'hA0,8'hA1,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,8'hA8,8'h5B,8'h2E,8'h3C,8'h28,8'h2B,8'h21,
    8'h26,8'hA9,8'hAA,8'hAB,8'hAC,8'hAD,8'hAE,8'hAF,8'hB0,8'hB1,8'h5D,8'h24,8'h2A,8'h29,8'h3B,8'h5E,
    8'h2D,8'h2F,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'h7C,8'h2C,8'h25,8'h5F,8'h3E,8'h3F,
    8'hBA,8'hBB,8'hBC,8'hBD,8'hBE,8'hBF,8'hC0,8'hC1,8'hC2,8'h60,8'h3A,8'h23,8'h40,8'h27,8'h3D,8'h22,
    8'hC3,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,
    8'hCA,8'h6A,8'h6B,8'h6C,8'h6D,8'h6E,8'h6F,8'h70,8'h71,8'h72,8'hCB,8'hCC,8'hCD,8'hCE,8'hCF,8'hD0,
    8'hD1,8'h7E,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7A,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,8'hD7,
    8'hD8,8'hD9,8'hDA,8'hDB,8'hDC,8'hDD,8'hDE,8'hDF,8'hE0,8'hE1,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,
    8'h7B,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'hE8,8'hE9,8'hEA,8'hEB,8'hEC,8'hED,
    8'h7D,8'h4A,8'h4B,8'h4C,8'h4D,8'h4E,8'h4F,8'h50,8'h51,8'h52,8'hEE,8'hEF,8'hF0,8'hF1,8'hF2,8'hF3,
    8'h5C,8'h9F,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5A,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,
    8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'hFA,8'hFB,8'hFC,8'hFD,8'hFE,8'hFF
  };

  localparam logic [7:0] A2E_STD [128] = '{
    8'h00,8'h01,8'h02,8'h03,8'h37,8'h2D,8'h2E,8'h2F,8'h16,8'h05,8'h25,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,
    8'h10,8'h11,8'h12,8'h13,8'h3C,8'h3D,8'h32,8'h26,8'h18,8'h19,8'h3F,8'h27,8'h1C,8'h1D,8'h1E,8'h1F,
    8'h40,8'h4F,8'h7F,8'h7B,8'h5B,8'h6C,8'h50,8'h7D,8'h4D,8'h5D,8'h5C,8'h4E,8'h6B,8'h60,8'h4B,8'h61,
    8'hF0,8'hF1,8'hF2,8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'h7A,8'h5E,8'h4C,8'h7E,8'h6E,8'h6F,
    8'h7C,8'hC1,8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,8'hD1,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,
    8'hD7,8'hD8,8'hD9,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'h4A,8'hE0,8'h5A,8'h5F,8'h6D,
    8'h79,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h91,8'h92,8'h93,8'h94,8'h95,8'h96,
    8'h97,8'h98,8'h99,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,8'hA8,8'hA9,8'hC0,8'h6A,8'hD0,8'hA1,8'h07
  };

  localparam logic [7:0] A2E_PRT [128] = '{
    8'h00,8'h01,8'h02,8'h03,8'h37,8'h2D,8'h2E,8'h2F,8'h16,8'h05,8'h25,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,
    8'h10,8'h11,8'h12,8'h13,8'h3C,8'h3D,8'h32,8'h26,8'h18,8'h19,8'h3F,8'h27,8'h1C,8'h1D,8'h1E,8'h1F,
    8'h40,8'h5A,8'h7F,8'h7B,8'h5B,8'h6C,8'h50,8'h7D,8'h4D,8'h5D,8'h5C,8'h4E,8'h6B,8'h60,8'h4B,8'h61,
    8'hF0,8'hF1,8'hF2,8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'h7A,8'h5E,8'h4C,8'h7E,8'h6E,8'h6F,
    8'h7C,8'hC1,8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,8'hD1,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,
    8'hD7,8'hD8,8'hD9,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'hAD,8'hE0,8'hBD,8'h4A,8'h6D,
    8'h7D,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h91,8'h92,8'h93,8'h94,8'h95,8'h96,
    8'h97,8'h98,8'h99,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,8'hA8,8'hA9,8'h8B,8'h4F,8'h9B,8'h5F,8'h07
  };

  // Case mapping on an ASCII byte; unused mode codes leave the byte alone.
  function automatic logic [7:0] fix_case(input logic [1:0] mode, input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (mode == CASE_UPPER && (c inside {[8'h61:8'h7A]})) begin
      r = c - 8'h20;
    end else if (mode == CASE_LOWER && (c inside {[8'h41:8'h5A]})) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

[src/erc_queue.sv]
module erc_queue #(
  parameter int DEPTH = erc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  erc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output erc_pkg::cmd_t head,
  output logic          head_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  erc_pkg::cmd_t   slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[src/erc_front.sv]
module erc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [5:0]    cfg_data,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tuser,
  input  logic          q_full,
  output logic          push,
  output erc_pkg::cmd_t push_cmd
);

  erc_pkg::xlate_t translate_mode_r;
  logic [1:0]      case_mode_r;
  logic            swap_pairs_r;
  logic [5:0]      record_length_r;

  logic [5:0] pos_r, pos_nxt;
  logic [5:0] pend_r, pend_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic [7:0] held_byte_r, held_byte_nxt;

  logic       accept, flush, rec_end, swap_now;
  logic [5:0] len, pos1, pad_cnt;
  logic [7:0] e_byte, c_byte, blk_byte, last_put;
  logic [7:0] rep_byte, mid_byte;
  logic [5:0] rep_cnt;
  logic       has_mid, has_end;
  logic [erc_pkg::CNT_W-1:0] puts, slen, n_out;

  localparam logic [erc_pkg::CNT_W-1:0] NMAX = erc_pkg::CNT_W'(erc_pkg::MAX_RESULTS);

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;
  assign flush     = (in_tuser == erc_pkg::ACT_FLUSH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      translate_mode_r <= erc_pkg::XL_COPY;
      case_mode_r      <= '0;
      swap_pairs_r     <= 1'b0;
      record_length_r  <= 6'(erc_pkg::MAX_RECORD);
    end else if (cfg_valid) begin
      case (erc_pkg::cfg_idx_t'(cfg_index))
        erc_pkg::CFG_TRANSLATE: translate_mode_r <= erc_pkg::xlate_t'(cfg_data[1:0]);
        erc_pkg::CFG_CASE:      case_mode_r      <= cfg_data[1:0];
        erc_pkg::CFG_SWAP:      swap_pairs_r     <= cfg_data[0];
        erc_pkg::CFG_RECLEN:    record_length_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero length acts as one byte; anything above the limit is clamped.
  always_comb begin
    len = record_length_r;
    if (record_length_r == '0) begin
      len = 6'd1;
    end else if (record_length_r > 6'(erc_pkg::MAX_RECORD)) begin
      len = 6'(erc_pkg::MAX_RECORD);
    end
  end

  assign pos1     = pos_r + 6'd1;
  assign rec_end  = (pos1 >= len);
  assign pad_cnt  = (pos_r < len) ? (len - pos_r) : '0;
  assign e_byte   = erc_pkg::E2A[in_tdata];
  assign c_byte   = erc_pkg::fix_case(case_mode_r, in_tdata);
  assign blk_byte = c_byte[7] ? 8'h00 :
                    (translate_mode_r == erc_pkg::XL_BLOCK_PRT) ?
                    erc_pkg::A2E_PRT[c_byte[6:0]] : erc_pkg::A2E_STD[c_byte[6:0]];

  // Classify the beat into a run of repeated bytes, a middle byte and a newline.
  always_comb begin
    rep_byte = erc_pkg::CH_ESPACE;
    rep_cnt  = '0;
    has_mid  = 1'b0;
    mid_byte = c_byte;
    has_end  = 1'b0;
    pos_nxt  = pos_r;
    pend_nxt = pend_r;
    if (!flush) begin
      case (translate_mode_r)
        erc_pkg::XL_COPY: begin
          has_mid = 1'b1;
        end
        erc_pkg::XL_UNBLOCK: begin
          if (e_byte == erc_pkg::CH_ASPACE) begin
            pend_nxt = pend_r + 6'd1;
          end else begin
            rep_byte = erc_pkg::CH_ASPACE;
            rep_cnt  = pend_r;
            has_mid  = 1'b1;
            mid_byte = erc_pkg::fix_case(case_mode_r, e_byte);
            pend_nxt = '0;
          end
          if (rec_end) begin
            has_end  = 1'b1;
            pos_nxt  = '0;
            pend_nxt = '0;
          end else begin
            pos_nxt = pos1;
          end
        end
        erc_pkg::XL_BLOCK, erc_pkg::XL_BLOCK_PRT: begin
          if (in_tdata == erc_pkg::CH_NL) begin
            rep_cnt = pad_cnt;
            pos_nxt = '0;
          end else begin
            has_mid  = 1'b1;
            mid_byte = blk_byte;
            pos_nxt  = rec_end ? '0 : pos1;
          end
        end
        default: ;
      endcase
    end else begin
      if (pos_r != '0) begin
        if (translate_mode_r == erc_pkg::XL_UNBLOCK) begin
          has_end = 1'b1;
        end else if (translate_mode_r != erc_pkg::XL_COPY) begin
          rep_cnt = pad_cnt;
        end
      end
      pos_nxt  = '0;
      pend_nxt = '0;
    end
  end

  // Pairing is counted here so that the back end only sees beats that emit.
  assign swap_now = swap_pairs_r || held_valid_r;
  assign puts     = erc_pkg::CNT_W'(rep_cnt) + erc_pkg::CNT_W'(has_mid)
                  + erc_pkg::CNT_W'(has_end);
  assign slen     = puts + erc_pkg::CNT_W'(held_valid_r);
  assign last_put = has_end ? erc_pkg::CH_NL : (has_mid ? mid_byte : rep_byte);

  always_comb begin
    if (flush) begin
      n_out = slen;
    end else if (swap_now) begin
      n_out = (slen >= NMAX) ? NMAX : {slen[erc_pkg::CNT_W-1:1], 1'b0};
    end else begin
      n_out = (slen > NMAX) ? NMAX : slen;
    end
  end

  always_comb begin
    held_valid_nxt = 1'b0;
    held_byte_nxt  = held_byte_r;
    if (!flush && swap_now) begin
      held_valid_nxt = slen[0] && (slen < NMAX);
      if (held_valid_nxt && puts != '0) begin
        held_byte_nxt = last_put;
      end
    end
  end

  assign push = accept && (n_out != '0);

  always_comb begin
    push_cmd.rep_byte  = rep_byte;
    push_cmd.rep_cnt   = rep_cnt;
    push_cmd.has_mid   = has_mid;
    push_cmd.mid_byte  = mid_byte;
    push_cmd.has_end   = has_end;
    push_cmd.held_in   = held_valid_r;
    push_cmd.held_byte = held_byte_r;
    push_cmd.swap      = swap_now;
    push_cmd.slen      = slen;
    push_cmd.n_out     = n_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      pend_r       <= '0;
      held_valid_r <= 1'b0;
      held_byte_r  <= '0;
    end else if (accept) begin
      pos_r        <= pos_nxt;
      pend_r       <= pend_nxt;
      held_valid_r <= held_valid_nxt;
      held_byte_r  <= held_byte_nxt;
    end
  end

endmodule

[src/erc_back.sv]
module erc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  erc_pkg::cmd_t head,
  input  logic          head_valid,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast
);

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [5:0] idx_r;

  logic                      load, is_last, tail;
  logic [erc_pkg::CNT_W-1:0] idx_inc;
  logic [5:0]                j, k;
  logic [7:0]                sel;

  assign load    = head_valid && (!out_valid_r || out_tready);
  assign idx_inc = erc_pkg::CNT_W'(idx_r) + 1'b1;
  assign is_last = (idx_inc == head.n_out);
  // An odd byte left at the end of a flush goes out unpaired.
  assign tail    = !idx_r[0] && (idx_inc == head.slen);
  assign j       = (head.swap && !tail) ? {idx_r[5:1], ~idx_r[0]} : idx_r;
  assign k       = j - 6'(head.held_in);

  always_comb begin
    if (head.held_in && j == '0) begin
      sel = head.held_byte;
    end else if (k < head.rep_cnt) begin
      sel = head.rep_byte;
    end else if (k == head.rep_cnt && head.has_mid) begin
      sel = head.mid_byte;
    end else begin
      sel = erc_pkg::CH_NL;
    end
  end

  assign pop = load && is_last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= sel;
      out_last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= is_last ? '0 : idx_inc[5:0];
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

endmodule

[src/ebcdic_ascii_record_converter.sv]
// Byte stream converter between EBCDIC fixed records and ASCII lines, with
// optional case mapping on the ASCII side and byte pair swapping on the output.
// A front end takes one input beat per cycle while the queue has room, keeps
// the record position, the withheld unblock spaces and the swap byte, and
// turns each beat into a short command; a command queue of QUEUE_DEPTH
// entries feeds a back end that sends one output beat per cycle while
// out_tready is high, through a registered output stage. An input beat that
// yields k output beats holds the back end until all k have gone (k up to 64,
// for instance a record padded with spaces); the front keeps accepting beats
// while the queue has room, so in steady translation the block moves one byte
// per clock in each direction when neither side stalls. A beat that yields
// nothing, such as a byte taken into the swap register or a trailing space,
// never enters the queue. The first output beat of a byte passes through the
// command queue and the output register before it is presented.
// Configuration writes are taken at any time but are meant to be made only
// while the block is idle.
module ebcdic_ascii_record_converter #(
  // Command queue depth between front and back end.
  parameter int QUEUE_DEPTH = erc_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,

  // Configuration writes: index 0 translate mode, 1 case mode, 2 swap pairs,
  // 3 record length.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data,

  // Input beats.
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tuser,   // [0] action: 0 data byte, 1 end of stream flush

  // Output beats.
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // final beat caused by one input beat
);

  erc_pkg::cmd_t push_cmd;
  erc_pkg::cmd_t head;
  logic          push, q_full, pop, head_valid;

  // The front classifies each beat and keeps all per-record state, so the
  // back end only has to walk through the bytes of one command.
  erc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // The queue lets input keep flowing while a long space run drains.
  erc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // The back end emits the command's bytes in output order, applying the pair
  // swap by index, and marks the last one of each command.
  erc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[src/erc_checker.sv]
`include "assert_macros.svh"

module erc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [1:0] cfg_index,
  input logic [5:0] cfg_data,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  logic in_beat;
  logic out_beat;

  assign in_beat  = in_tvalid && in_tready;
  assign out_beat = out_tvalid && out_tready;

  // Reset empties the output stage.
  `ERC_ASSERT_NR(a_reset_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")

  // A stalled output beat keeps its contents.
  `ERC_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output beat changed while stalled")

  // The bytes of one input beat leave without gaps once the first has gone.
  `ERC_ASSERT(a_no_gap, clk, rst_n, out_beat && !out_tlast |=> out_tvalid, "gap inside the output of one input beat")

  // From idle, output rises after an input beat via queue and output register.
  `ERC_ASSERT(a_start_after_input, clk, rst_n, $rose(out_tvalid) |-> $past(in_beat, 2), "output without a preceding input beat")

endmodule

bind ebcdic_ascii_record_converter erc_checker u_erc_checker (.*);
